/* hw/rtl/ccbcd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the calendar clock block.
// Depends on nothing; the input stage, the core, the top level and the bench import it.
package ccbcd_pkg;

  // Command codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Field limits.
  localparam logic [13:0] YEAR_LIMIT = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINUTE_MAX = 6'd59;
  localparam logic [5:0]  SECOND_MAX = 6'd59;
  localparam logic [4:0]  DAY_LAST   = 5'd31;
  localparam logic [6:0]  CENT_MAX   = 7'd99;

  // Values after reset: 2000-01-01 00:00:00.
  localparam logic [13:0] YEAR_RESET    = 14'd2000;
  localparam logic [6:0]  YEAR_HI_RESET = 7'd20;
  localparam logic [6:0]  YEAR_LO_RESET = 7'd0;
  localparam logic [3:0]  MONTH_RESET   = 4'd1;
  localparam logic [4:0]  DAY_RESET     = 5'd1;

  // Multiplier for the year split: floor(y * 5243 / 2^19) equals y / 100 below 10000.
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int          CENT_SHIFT = 19;

  // A registered command with the set fields already saturated (except the day)
  // and the year split into its century and year-of-century parts.
  typedef struct packed {
    logic        opcode;
    logic [31:0] timer_count;
    logic [13:0] year;
    logic [6:0]  year_hi;
    logic [6:0]  year_lo;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ccbcd_cmd_t;

  // Two packed BCD digits of a value below 100; v * 103 / 1024 is v / 10 there.
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {7'd0, v} * 14'd103;
    tens = prod[13:10];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // Gregorian leap test from the two halves of the year.
  function automatic logic is_leap(input logic [6:0] hi, input logic [6:0] lo);
    logic leap;
    if (lo == 7'd0) begin
      leap = (hi[1:0] == 2'd0);
    end else begin
      leap = (lo[1:0] == 2'd0);
    end
    return leap;
  endfunction

  // Length of a month; months outside 1..12 never reach here and read as 31.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/ccbcd_cmd_if.sv */
`timescale 1ns / 1ps
// Command channel of the calendar clock: valid/ready handshake with tick and set fields.
// Stands alone; used by the top level and the input stage.
interface ccbcd_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] timer_count;
  logic [13:0] set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;
  logic [4:0]  set_hour;
  logic [5:0]  set_minute;
  logic [5:0]  set_second;

  modport source (
    output valid, opcode, timer_count, set_year, set_month, set_day, set_hour,
           set_minute, set_second,
    input  ready
  );

  modport sink (
    input  valid, opcode, timer_count, set_year, set_month, set_day, set_hour,
           set_minute, set_second,
    output ready
  );
endinterface

/* hw/rtl/ccbcd_res_if.sv */
`timescale 1ns / 1ps
// Result channel of the calendar clock: valid/ready handshake with the time in BCD.
// Stands alone; used by the top level and the time core.
interface ccbcd_res_if;
  logic        valid;
  logic        ready;
  logic        advanced;
  logic [13:0] year_binary;
  logic [15:0] year_bcd;
  logic [7:0]  month_bcd;
  logic [7:0]  day_bcd;
  logic [7:0]  hour_bcd;
  logic [7:0]  minute_bcd;
  logic [7:0]  second_bcd;

  modport source (
    output valid, advanced, year_binary, year_bcd, month_bcd, day_bcd, hour_bcd,
           minute_bcd, second_bcd,
    input  ready
  );

  modport sink (
    input  valid, advanced, year_binary, year_bcd, month_bcd, day_bcd, hour_bcd,
           minute_bcd, second_bcd,
    output ready
  );
endinterface

/* hw/rtl/ccbcd_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the calendar clock: saturates the set fields and splits the year.
// Depends on ccbcd_pkg and ccbcd_cmd_if.
module ccbcd_in_stage
  import ccbcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ccbcd_cmd_if.sink     cmd,
  input  logic          advance,
  output logic          stage_valid,
  output ccbcd_cmd_t    stage_data
);

  logic        take;
  logic [13:0] year_sat;
  logic [26:0] cent_prod;
  logic [6:0]  cent_hi;
  logic [13:0] cent_rest;
  ccbcd_cmd_t  data_next;

  // The register is free when empty or when its content moves on this cycle.
  assign cmd.ready = !stage_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  // Saturate the set fields and split the year into hundreds and the rest.
  always_comb begin
    year_sat  = (cmd.set_year > YEAR_LIMIT) ? YEAR_LIMIT : cmd.set_year;
    cent_prod = {13'd0, year_sat} * {14'd0, CENT_RECIP};
    cent_hi   = cent_prod[CENT_SHIFT +: 7];
    cent_rest = year_sat - ({7'd0, cent_hi} * 14'd100);

    data_next.opcode      = cmd.opcode;
    data_next.timer_count = cmd.timer_count;
    data_next.year        = year_sat;
    data_next.year_hi     = cent_hi;
    data_next.year_lo     = cent_rest[6:0];
    if (cmd.set_month == 4'd0) begin
      data_next.month = 4'd1;
    end else if (cmd.set_month > MONTH_MAX) begin
      data_next.month = MONTH_MAX;
    end else begin
      data_next.month = cmd.set_month;
    end
    data_next.day    = cmd.set_day;
    data_next.hour   = (cmd.set_hour > HOUR_MAX) ? HOUR_MAX : cmd.set_hour;
    data_next.minute = (cmd.set_minute > MINUTE_MAX) ? MINUTE_MAX : cmd.set_minute;
    data_next.second = (cmd.set_second > SECOND_MAX) ? SECOND_MAX : cmd.set_second;
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (take) begin
      stage_data <= data_next;
    end
  end

endmodule

/* hw/rtl/ccbcd_core.sv */
`timescale 1ns / 1ps
// Time core of the calendar clock: calendar state, one-second carry chain,
// set loading and the BCD result register. Depends on ccbcd_pkg and ccbcd_res_if.
module ccbcd_core
  import ccbcd_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 4
)(
  input  logic          clk,
  input  logic          rst,
  input  logic          stage_valid,
  input  ccbcd_cmd_t    stage_data,
  output logic          advance,
  ccbcd_res_if.source   res
);

  localparam logic [31:0] TPS = 32'(TICKS_PER_SECOND);

  // Calendar state.
  logic [31:0] reference_count;
  logic [13:0] year_value;
  logic [6:0]  year_hi;
  logic [6:0]  year_lo;
  logic [3:0]  month_value;
  logic [4:0]  day_value;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;

  logic [31:0] reference_count_next;
  logic [13:0] year_value_next;
  logic [6:0]  year_hi_next;
  logic [6:0]  year_lo_next;
  logic [3:0]  month_value_next;
  logic [4:0]  day_value_next;
  logic [4:0]  hour_value_next;
  logic [5:0]  minute_value_next;
  logic [5:0]  second_value_next;
  logic        advanced_next;

  logic [31:0] diff;
  logic        due;
  logic        frozen;
  logic [4:0]  cur_len;
  logic [4:0]  set_len;
  logic        do_step;

  // The result register frees up when empty or when its result is taken.
  assign advance = !res.valid || res.ready;
  assign do_step = advance && stage_valid;

  // Next calendar state for a tick or a set.
  always_comb begin
    reference_count_next = reference_count;
    year_value_next      = year_value;
    year_hi_next         = year_hi;
    year_lo_next         = year_lo;
    month_value_next     = month_value;
    day_value_next       = day_value;
    hour_value_next      = hour_value;
    minute_value_next    = minute_value;
    second_value_next    = second_value;
    advanced_next        = 1'b0;

    diff    = stage_data.timer_count - reference_count;
    due     = (diff >= TPS);
    frozen  = (year_value >= YEAR_LIMIT) && (month_value == MONTH_MAX) &&
              (day_value == DAY_LAST) && (hour_value == HOUR_MAX) &&
              (minute_value == MINUTE_MAX) && (second_value == SECOND_MAX);
    cur_len = month_len(month_value, is_leap(year_hi, year_lo));
    set_len = month_len(stage_data.month, is_leap(stage_data.year_hi, stage_data.year_lo));

    if (stage_data.opcode == OP_TICK) begin
      if (due) begin
        reference_count_next = reference_count + TPS;
        if (!frozen) begin
          advanced_next = 1'b1;
          // Carry one second through the fields in turn.
          if (second_value < SECOND_MAX) begin
            second_value_next = second_value + 6'd1;
          end else begin
            second_value_next = 6'd0;
            if (minute_value < MINUTE_MAX) begin
              minute_value_next = minute_value + 6'd1;
            end else begin
              minute_value_next = 6'd0;
              if (hour_value < HOUR_MAX) begin
                hour_value_next = hour_value + 5'd1;
              end else begin
                hour_value_next = 5'd0;
                if (day_value < cur_len) begin
                  day_value_next = day_value + 5'd1;
                end else begin
                  day_value_next = 5'd1;
                  if (month_value < MONTH_MAX) begin
                    month_value_next = month_value + 4'd1;
                  end else begin
                    month_value_next = 4'd1;
                    year_value_next  = year_value + 14'd1;
                    if (year_lo == CENT_MAX) begin
                      year_lo_next = 7'd0;
                      year_hi_next = year_hi + 7'd1;
                    end else begin
                      year_lo_next = year_lo + 7'd1;
                    end
                  end
                end
              end
            end
          end
        end
      end
    end else begin
      // Load the set fields; the day is clamped to the loaded month.
      year_value_next   = stage_data.year;
      year_hi_next      = stage_data.year_hi;
      year_lo_next      = stage_data.year_lo;
      month_value_next  = stage_data.month;
      hour_value_next   = stage_data.hour;
      minute_value_next = stage_data.minute;
      second_value_next = stage_data.second;
      if (stage_data.day == 5'd0) begin
        day_value_next = 5'd1;
      end else if (stage_data.day > set_len) begin
        day_value_next = set_len;
      end else begin
        day_value_next = stage_data.day;
      end
    end
  end

  // Calendar state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_count <= 32'd0;
      year_value      <= YEAR_RESET;
      year_hi         <= YEAR_HI_RESET;
      year_lo         <= YEAR_LO_RESET;
      month_value     <= MONTH_RESET;
      day_value       <= DAY_RESET;
      hour_value      <= 5'd0;
      minute_value    <= 6'd0;
      second_value    <= 6'd0;
    end else if (do_step) begin
      reference_count <= reference_count_next;
      year_value      <= year_value_next;
      year_hi         <= year_hi_next;
      year_lo         <= year_lo_next;
      month_value     <= month_value_next;
      day_value       <= day_value_next;
      hour_value      <= hour_value_next;
      minute_value    <= minute_value_next;
      second_value    <= second_value_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= stage_valid;
    end
  end

  // Result payload in packed BCD.
  always_ff @(posedge clk) begin
    if (do_step) begin
      res.advanced    <= advanced_next;
      res.year_binary <= year_value_next;
      res.year_bcd    <= {bcd2(year_hi_next), bcd2(year_lo_next)};
      res.month_bcd   <= bcd2({3'd0, month_value_next});
      res.day_bcd     <= bcd2({2'd0, day_value_next});
      res.hour_bcd    <= bcd2({2'd0, hour_value_next});
      res.minute_bcd  <= bcd2({1'd0, minute_value_next});
      res.second_bcd  <= bcd2({1'd0, second_value_next});
    end
  end

endmodule

/* hw/rtl/calendar_clock_with_bcd_top.sv */
`timescale 1ns / 1ps
// Top level of the calendar clock with BCD output.
// Depends on ccbcd_pkg, ccbcd_cmd_if, ccbcd_res_if, ccbcd_in_stage and ccbcd_core.
//
//   Channel  Direction  Carries
//   cmd      in         opcode, timer_count, set_year .. set_second
//   res      out        advanced, year_binary, year_bcd .. second_bcd
//
// Every command gives exactly one result, via the input register and the result register.
// A command can be taken in every cycle unless the result stalls; the calendar state is
// read and written in the same cycle by the carry chain, so commands follow without a gap.
// Reset is synchronous and sets the time to 2000-01-01 00:00:00 with a zero reference.
// With the result stalled, the input register still takes one more command.
module calendar_clock_with_bcd_top
  import ccbcd_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 4
)(
  input  logic        clk,
  input  logic        rst,
  ccbcd_cmd_if.sink   cmd,
  ccbcd_res_if.source res
);

  logic       stage_valid;
  ccbcd_cmd_t stage_data;
  logic       advance;

  // Input register with set-field saturation.
  ccbcd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  // Calendar state and result register.
  ccbcd_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .advance     (advance),
    .res         (res)
  );

endmodule

/* hw/rtl/ccbcd_checker.sv */
`timescale 1ns / 1ps
// Port checker for the calendar clock, bound to the top level.
// Depends on the port list of calendar_clock_with_bcd_top.
module ccbcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  month_bcd,
  input logic [7:0]  day_bcd,
  input logic [7:0]  hour_bcd,
  input logic [7:0]  minute_bcd,
  input logic [7:0]  second_bcd
);

  // A stalled result stays and keeps its time.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(second_bcd) && $stable(day_bcd))
    else $error("result changed while stalled");

  // With no result pending the pipeline must be able to take a command.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("command refused with the result register empty");

  // Seconds and minutes are legal BCD below 60.
  a_sec_min_bcd: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (second_bcd[7:4] <= 4'd5) && (second_bcd[3:0] <= 4'd9) &&
                  (minute_bcd[7:4] <= 4'd5) && (minute_bcd[3:0] <= 4'd9))
    else $error("second or minute out of range");

  // Hour, month and day stay within calendar range.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hour_bcd <= 8'h23) && (month_bcd >= 8'h01) && (month_bcd <= 8'h12) &&
                  (day_bcd >= 8'h01) && (day_bcd <= 8'h31))
    else $error("hour, month or day out of range");

endmodule

bind calendar_clock_with_bcd_top ccbcd_checker u_ccbcd_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .month_bcd  (res.month_bcd),
  .day_bcd    (res.day_bcd),
  .hour_bcd   (res.hour_bcd),
  .minute_bcd (res.minute_bcd),
  .second_bcd (res.second_bcd)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for calendar_clock_with_bcd_top: directed rows, then random
// tick and set commands with stalls on both channels. Depends on ccbcd_pkg and the two
// channel interfaces.
module tb_top;
  import ccbcd_pkg::*;

  localparam int          TPS        = 4;
  localparam int unsigned LAST_YEAR  = 9999;
  localparam int          RAND_ITEMS = 1026;
  localparam int          QUIET_TAIL = 150;
  localparam int          LONG_HOLD  = 64;
  localparam int          DRAIN      = 10;
  localparam int          MAX_PRINTS = 30;

  typedef struct packed {
    logic        opcode;
    logic [31:0] timer_count;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } clock_cmd_t;

  typedef struct packed {
    logic        advanced;
    logic [13:0] year_bin;
    logic [15:0] year_bcd;
    logic [7:0]  month_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
  } clock_reading_t;

  typedef struct {
    clock_cmd_t     cmd;
    bit             typed;
    clock_reading_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  ccbcd_cmd_if cmd_ch ();
  ccbcd_res_if res_ch ();

  calendar_clock_with_bcd_top #(
    .TICKS_PER_SECOND(TPS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Calendar predictor state.
  logic [31:0] ref_count;
  logic [13:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;

  clock_reading_t pending_readings[$];
  stim_row_t      stim_rows[$];
  logic [31:0]    timer_now;
  bit             idle_on;
  bit             hold_request;

  int unsigned items_sent;
  int unsigned tick_count;
  int unsigned set_count;
  int unsigned second_steps;
  int unsigned year_rollovers;
  int unsigned frozen_ticks;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned long_holds;

  function automatic bit leap_year(int unsigned y);
    return (((y % 4) == 0) && ((y % 100) != 0)) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2:           len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] bcd_pair(int unsigned v);
    logic [3:0] tens;
    logic [3:0] ones;
    tens = 4'((v / 10) % 10);
    ones = 4'(v % 10);
    return {tens, ones};
  endfunction

  // One second forward with the full carry chain; the clock stops at the last
  // second of year 9999.
  function automatic bit tick_one_second();
    if (cal_year >= 14'(LAST_YEAR) && cal_month == 4'd12 && cal_day == 5'd31 &&
        cal_hour == 5'd23 && cal_minute == 6'd59 && cal_second == 6'd59) begin
      frozen_ticks++;
      return 1'b0;
    end
    if (cal_second < 6'd59) begin
      cal_second = cal_second + 6'd1;
      return 1'b1;
    end
    cal_second = 6'd0;
    if (cal_minute < 6'd59) begin
      cal_minute = cal_minute + 6'd1;
      return 1'b1;
    end
    cal_minute = 6'd0;
    if (cal_hour < 5'd23) begin
      cal_hour = cal_hour + 5'd1;
      return 1'b1;
    end
    cal_hour = 5'd0;
    if (cal_day < 5'(month_length(32'(cal_year), 32'(cal_month)))) begin
      cal_day = cal_day + 5'd1;
      return 1'b1;
    end
    cal_day = 5'd1;
    if (cal_month < 4'd12) begin
      cal_month = cal_month + 4'd1;
      return 1'b1;
    end
    cal_month = 4'd1;
    cal_year = cal_year + 14'd1;
    year_rollovers++;
    return 1'b1;
  endfunction

  // Applies one command to the predicted calendar and returns the reading that follows.
  function automatic clock_reading_t apply_command(clock_cmd_t c);
    clock_reading_t r;
    logic [31:0]    lag;
    int unsigned    y;
    int unsigned    m;
    int unsigned    d;
    int unsigned    lim;
    r.advanced = 1'b0;
    if (c.opcode == OP_TICK) begin
      tick_count++;
      lag = c.timer_count - ref_count;
      if (lag >= 32'(TPS)) begin
        ref_count = ref_count + 32'(TPS);
        r.advanced = tick_one_second();
      end
    end else begin
      set_count++;
      y = 32'(c.set_year);
      m = 32'(c.set_month);
      d = 32'(c.set_day);
      if (y > LAST_YEAR) y = LAST_YEAR;
      if (m == 0) m = 1;
      if (m > 12) m = 12;
      lim = month_length(y, m);
      if (d == 0) d = 1;
      if (d > lim) d = lim;
      cal_year   = 14'(y);
      cal_month  = 4'(m);
      cal_day    = 5'(d);
      cal_hour   = (c.set_hour > 5'd23) ? 5'd23 : c.set_hour;
      cal_minute = (c.set_minute > 6'd59) ? 6'd59 : c.set_minute;
      cal_second = (c.set_second > 6'd59) ? 6'd59 : c.set_second;
    end
    if (r.advanced) second_steps++;
    r.year_bin   = cal_year;
    r.year_bcd   = {bcd_pair(32'(cal_year) / 100), bcd_pair(32'(cal_year) % 100)};
    r.month_bcd  = bcd_pair(32'(cal_month));
    r.day_bcd    = bcd_pair(32'(cal_day));
    r.hour_bcd   = bcd_pair(32'(cal_hour));
    r.minute_bcd = bcd_pair(32'(cal_minute));
    r.second_bcd = bcd_pair(32'(cal_second));
    return r;
  endfunction

  // Random command: mostly ticks from a running timer, with sets that land close to
  // a rollover, plus some out-of-range sets and timer jumps.
  function automatic clock_cmd_t random_command();
    clock_cmd_t  c;
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    c.timer_count = $urandom;
    c.set_year    = 14'($urandom);
    c.set_month   = 4'($urandom);
    c.set_day     = 5'($urandom);
    c.set_hour    = 5'($urandom);
    c.set_minute  = 6'($urandom);
    c.set_second  = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      c.opcode = OP_SET;
      if (pick < 6) begin
        case ($urandom_range(0, 5))
          0:       y = LAST_YEAR;
          1:       y = $urandom_range(16, 24) * 100;
          2:       y = 4 * $urandom_range(0, 2499);
          3:       y = 0;
          default: y = $urandom_range(0, LAST_YEAR);
        endcase
        m = ($urandom_range(0, 2) == 0) ? 12 : $urandom_range(1, 12);
        c.set_year   = 14'(y);
        c.set_month  = 4'(m);
        c.set_day    = 5'(month_length(y, m) - $urandom_range(0, 1));
        c.set_hour   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23)) : 5'd23;
        c.set_minute = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 59)) : 6'd59;
        c.set_second = 6'($urandom_range(50, 59));
      end else if (pick < 8) begin
        c.set_year   = 14'($urandom_range(0, LAST_YEAR));
        c.set_month  = 4'($urandom_range(1, 12));
        c.set_day    = 5'($urandom_range(1, 31));
        c.set_hour   = 5'($urandom_range(0, 23));
        c.set_minute = 6'($urandom_range(0, 59));
        c.set_second = 6'($urandom_range(0, 59));
      end
    end else begin
      c.opcode = OP_TICK;
      if (pick < 12) begin
        c.timer_count = ref_count - 32'($urandom_range(1, 8));
      end else if (pick >= 14) begin
        // A free-running timer; it is pulled back to the reference if it fell behind.
        if ($urandom_range(0, 29) == 0) begin
          timer_now = timer_now + 32'($urandom_range(8, 40));
        end else begin
          timer_now = timer_now + 32'($urandom_range(0, 6));
        end
        if ($signed(timer_now - ref_count) < 0) timer_now = ref_count;
        c.timer_count = timer_now;
      end
    end
    return c;
  endfunction

  task automatic add_tick(input logic [31:0] count, input bit typed = 1'b0,
                          input clock_reading_t want = '0);
    stim_row_t row;
    row.cmd             = '0;
    row.cmd.opcode      = OP_TICK;
    row.cmd.timer_count = count;
    row.cmd.set_year    = 14'($urandom);
    row.cmd.set_month   = 4'($urandom);
    row.cmd.set_day     = 5'($urandom);
    row.typed           = typed;
    row.want            = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_set(input int unsigned y, input int unsigned mo, input int unsigned d,
                         input int unsigned h, input int unsigned mi, input int unsigned s,
                         input bit typed = 1'b0, input clock_reading_t want = '0);
    stim_row_t row;
    row.cmd.opcode      = OP_SET;
    row.cmd.timer_count = $urandom;
    row.cmd.set_year    = 14'(y);
    row.cmd.set_month   = 4'(mo);
    row.cmd.set_day     = 5'(d);
    row.cmd.set_hour    = 5'(h);
    row.cmd.set_minute  = 6'(mi);
    row.cmd.set_second  = 6'(s);
    row.typed           = typed;
    row.want            = want;
    stim_rows.push_back(row);
  endtask

  // Drives one command, waits for its transfer and records the expected reading.
  task automatic send_command(input clock_cmd_t c, input bit typed,
                              input clock_reading_t want);
    clock_reading_t predicted;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= c.opcode;
    cmd_ch.timer_count <= c.timer_count;
    cmd_ch.set_year    <= c.set_year;
    cmd_ch.set_month   <= c.set_month;
    cmd_ch.set_day     <= c.set_day;
    cmd_ch.set_hour    <= c.set_hour;
    cmd_ch.set_minute  <= c.set_minute;
    cmd_ch.set_second  <= c.set_second;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = apply_command(c);
    pending_readings.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic note_mismatch(input string field, input int unsigned idx,
                               input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $time, idx, field, got, want);
    end
  endtask

  // Command side: reset, directed rows, then the random stream.
  initial begin : command_side
    clock_cmd_t c;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= OP_TICK;
    cmd_ch.timer_count <= '0;
    cmd_ch.set_year    <= '0;
    cmd_ch.set_month   <= '0;
    cmd_ch.set_day     <= '0;
    cmd_ch.set_hour    <= '0;
    cmd_ch.set_minute  <= '0;
    cmd_ch.set_second  <= '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    ref_count    = '0;
    cal_year     = 14'd2000;
    cal_month    = 4'd1;
    cal_day      = 5'd1;
    cal_hour     = '0;
    cal_minute   = '0;
    cal_second   = '0;

    // Reset value, ticks just short of and at one second, reference wrap-around.
    add_tick(32'd0, 1'b1, '{1'b0, 14'd2000, 16'h2000, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
    add_tick(32'd3, 1'b1, '{1'b0, 14'd2000, 16'h2000, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
    add_tick(32'd4, 1'b1, '{1'b1, 14'd2000, 16'h2000, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01});
    add_tick(32'hFFFF_FFFF);
    add_tick(32'd2);
    // All-ones set saturates to the very last second; a due tick then stays frozen.
    add_set(16383, 15, 31, 31, 63, 63, 1'b1,
            '{1'b0, 14'd9999, 16'h9999, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
    add_tick(32'd100, 1'b1, '{1'b0, 14'd9999, 16'h9999, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
    add_set(0, 0, 0, 0, 0, 0, 1'b1,
            '{1'b0, 14'd0, 16'h0000, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
    // Day clamped to the month length, with the leap rules.
    add_set(1900, 2, 31, 12, 34, 56);
    add_set(2000, 2, 31, 1, 2, 3);
    add_set(2023, 2, 30, 4, 5, 6);
    add_set(2024, 2, 30, 7, 8, 9);
    add_set(2023, 4, 31, 10, 11, 12);
    add_set(2023, 13, 31, 13, 14, 15);
    add_set(10000, 0, 0, 24, 60, 60, 1'b1,
            '{1'b0, 14'd9999, 16'h9999, 8'h01, 8'h01, 8'h23, 8'h59, 8'h59});
    // Rollovers across the year, into a leap day and past a skipped leap day.
    add_set(1999, 12, 31, 23, 59, 59);
    add_tick(32'h8000_0000);
    add_set(2024, 2, 28, 23, 59, 59);
    add_tick(32'h8000_0000);
    add_set(2100, 2, 28, 23, 59, 59);
    add_tick(32'h8000_0000);
    // Last step before the end of year 9999, then the frozen clock.
    add_set(9999, 12, 31, 23, 59, 58);
    add_tick(32'h8000_0000, 1'b1,
             '{1'b1, 14'd9999, 16'h9999, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
    add_tick(32'h8000_0000, 1'b1,
             '{1'b0, 14'd9999, 16'h9999, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_command(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);
    end

    timer_now = ref_count;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 120) hold_request = 1'b1;
      if (n == RAND_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      c = random_command();
      send_command(c, 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding results.
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d commands (%0d ticks, %0d sets) with %0d one-second steps,",
             items_sent, tick_count, set_count, second_steps);
    $display("%0d year rollovers, %0d frozen ticks, %0d long result stalls; %0d results checked.",
             year_rollovers, frozen_ticks, long_holds, results_checked);
    if (mismatch_count == 0) begin
      $display("calendar_clock_with_bcd_top verification clean");
    end else begin
      $display("calendar_clock_with_bcd_top verification failed");
    end
    $finish;
  end

  // Result side: ready with random stalls, and one long hold-off that backs up the block.
  initial begin : result_side
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        for (int held = 0; held < LONG_HOLD; held++) @(posedge clk);
        hold_request = 1'b0;
        long_holds++;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every result transfer with the oldest expected reading.
  always @(posedge clk) begin
    clock_reading_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_readings.size() == 0) begin
        note_mismatch("unexpected result", results_checked, '0, '0);
      end else begin
        want = pending_readings.pop_front();
        if (res_ch.advanced !== want.advanced)
          note_mismatch("advanced", results_checked,
                        32'(res_ch.advanced), 32'(want.advanced));
        if (res_ch.year_binary !== want.year_bin)
          note_mismatch("year_binary", results_checked,
                        32'(res_ch.year_binary), 32'(want.year_bin));
        if (res_ch.year_bcd !== want.year_bcd)
          note_mismatch("year_bcd", results_checked,
                        32'(res_ch.year_bcd), 32'(want.year_bcd));
        if (res_ch.month_bcd !== want.month_bcd)
          note_mismatch("month_bcd", results_checked,
                        32'(res_ch.month_bcd), 32'(want.month_bcd));
        if (res_ch.day_bcd !== want.day_bcd)
          note_mismatch("day_bcd", results_checked,
                        32'(res_ch.day_bcd), 32'(want.day_bcd));
        if (res_ch.hour_bcd !== want.hour_bcd)
          note_mismatch("hour_bcd", results_checked,
                        32'(res_ch.hour_bcd), 32'(want.hour_bcd));
        if (res_ch.minute_bcd !== want.minute_bcd)
          note_mismatch("minute_bcd", results_checked,
                        32'(res_ch.minute_bcd), 32'(want.minute_bcd));
        if (res_ch.second_bcd !== want.second_bcd)
          note_mismatch("second_bcd", results_checked,
                        32'(res_ch.second_bcd), 32'(want.second_bcd));
      end
      results_checked++;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("calendar_clock_with_bcd_top verification failed");
    $finish;
  end

endmodule
